[src/clni_pkg.sv]
`timescale 1ns / 1ps

package clni_pkg;

   localparam int LINE_BUFFER_LEN = 40;

   localparam int OP_W     = 3;
   localparam int BYTE_W   = 8;
   localparam int NIB_W    = 4;
   localparam int COL_W    = 6;
   localparam int ROW_W    = 2;
   localparam int SLOT_W   = 3;
   localparam int ROWS_W   = 64;
   localparam int CSR_IDX_W = 2;
   localparam int PULSE_W  = 5;
   localparam int BIDX_W   = 4;

   localparam logic [OP_W-1:0] OP_INIT   = 3'd0;
   localparam logic [OP_W-1:0] OP_CMD    = 3'd1;
   localparam logic [OP_W-1:0] OP_CHAR   = 3'd2;
   localparam logic [OP_W-1:0] OP_CURSOR = 3'd3;
   localparam logic [OP_W-1:0] OP_GLYPH  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_FUNCTION_SET = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_ON   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_MODE   = 2'd2;

   localparam logic [BYTE_W-1:0] FUNCTION_SET_RST = 8'h28;
   localparam logic [BYTE_W-1:0] DISPLAY_ON_RST   = 8'h0C;
   localparam logic [BYTE_W-1:0] ENTRY_MODE_RST   = 8'h06;

   localparam logic [BYTE_W-1:0] CMD_CLEAR     = 8'h01;
   localparam logic [BYTE_W-1:0] CMD_SET_CGRAM = 8'h40;
   localparam logic [BYTE_W-1:0] CMD_SET_DDRAM = 8'h80;

   localparam logic [NIB_W-1:0] NIB_WAKE  = 4'h3;
   localparam logic [NIB_W-1:0] NIB_4BIT  = 4'h2;
   localparam logic [NIB_W-1:0] NIB_MASK  = 4'hF;

   localparam logic [COL_W-1:0] WRAP_COL = COL_W'(LINE_BUFFER_LEN - 1);

   localparam logic [PULSE_W-1:0] WAKE_PULSES   = 5'd3;
   localparam logic [PULSE_W-1:0] PRE_PULSES    = 5'd4;
   localparam logic [PULSE_W-1:0] INIT_PULSES   = 5'd14;
   localparam logic [PULSE_W-1:0] BYTE_PULSES   = 5'd2;
   localparam logic [PULSE_W-1:0] WRAP_PULSES   = 5'd4;
   localparam logic [PULSE_W-1:0] GLYPH_PULSES  = 5'd20;

   localparam logic [BIDX_W-1:0] GLYPH_CURSOR_BYTE = 4'd9;

   function automatic logic [BYTE_W-1:0] row_base(input logic [ROW_W-1:0] r);
      logic [BYTE_W-1:0] base;
      unique case (r)
         2'd0: base = 8'h00;
         2'd1: base = 8'h40;
         2'd2: base = 8'h14;
         2'd3: base = 8'h54;
      endcase
      return base;
   endfunction

endpackage

[src/clni_if.sv]
`timescale 1ns / 1ps

interface clni_req_if
   import clni_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [BYTE_W-1:0]   byte_value;
   logic [COL_W-1:0]    column;
   logic [ROW_W-1:0]    row;
   logic [SLOT_W-1:0]   glyph_slot;
   logic [ROWS_W-1:0]   glyph_rows;

   modport source (output valid, op, byte_value, column, row, glyph_slot, glyph_rows,
                   input ready);
   modport sink   (input valid, op, byte_value, column, row, glyph_slot, glyph_rows,
                   output ready);
endinterface

interface clni_rsp_if
   import clni_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               reg_select;
   logic [NIB_W-1:0]   nibble;
   logic               long_wait;
   logic               last;

   modport source (output valid, reg_select, nibble, long_wait, last, input ready);
   modport sink   (input valid, reg_select, nibble, long_wait, last, output ready);
endinterface

interface clni_csr_if
   import clni_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [BYTE_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[src/char_lcd_nibble_interface_core.sv]
// The request is first registered into the run state; the first pulse is then loaded into
// the output register once it is free. Throughput: one pulse per cycle while rsp is ready;
// a pulse counter driving a byte/nibble selector emits 2, 4, 14 or 20 pulses (op-dependent)
// while the request holds the input; the next request is taken once the final pulse is loaded.
// Reset (synchronous, active high) clears the cursor, the sequencer and the output
// valid, and restores the init command registers to 0x28, 0x0C and 0x06.
`timescale 1ns / 1ps

module char_lcd_nibble_interface_core
   import clni_pkg::*;
   (
   input  logic        clock,
   input  logic        reset,
   clni_req_if.sink    req,
   clni_rsp_if.source  rsp,
   clni_csr_if.sink    csr
   );

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type           state_ff;
   logic [OP_W-1:0]     op_ff;
   logic [BYTE_W-1:0]   val_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [ROWS_W-1:0]   rows_ff;
   logic [BYTE_W-1:0]   addr_ff;
   logic                wrap_ff;
   logic [PULSE_W-1:0]  pulse_ff;
   logic [PULSE_W-1:0]  count_ff;
   logic [COL_W-1:0]    col_ff;
   logic [ROW_W-1:0]    row_ff;
   logic [BYTE_W-1:0]   fs_ff;
   logic [BYTE_W-1:0]   don_ff;
   logic [BYTE_W-1:0]   em_ff;

   logic                rsp_valid_ff;
   logic                rs_ff;
   logic [NIB_W-1:0]    nib_ff;
   logic                wait_ff;
   logic                last_ff;

   logic                accept;
   logic                load;
   logic                known_op;
   logic                wrap_in;
   logic [COL_W-1:0]    col_in;
   logic [ROW_W-1:0]    row_in;
   logic [PULSE_W-1:0]  count_in;
   logic [ROW_W-1:0]    sum_row;
   logic [COL_W-1:0]    sum_col;
   logic [BYTE_W-1:0]   addr_in;

   logic [PULSE_W-1:0]  pulse_adj;
   logic [BIDX_W-1:0]   byte_idx;
   logic [BYTE_W-1:0]   cur_byte;
   logic                rs_in;
   logic [NIB_W-1:0]    nib_in;
   logic                wait_in;
   logic                single;
   logic                last_in;
   logic                shift_rows;

   assign req.ready  = (state_ff == ST_IDLE);
   assign csr.ready  = 1'b1;
   assign accept     = req.valid && req.ready;
   assign load       = (state_ff == ST_RUN) && (!rsp_valid_ff || rsp.ready);
   assign known_op   = (req.op == OP_INIT) || (req.op == OP_CMD) || (req.op == OP_CHAR)
                    || (req.op == OP_CURSOR) || (req.op == OP_GLYPH);

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.reg_select = rs_ff;
   assign rsp.nibble     = nib_ff;
   assign rsp.long_wait  = wait_ff;
   assign rsp.last       = last_ff;

   // cursor update and the one shared address adder, evaluated at accept
   always_comb begin
      wrap_in  = 1'b0;
      col_in   = col_ff;
      row_in   = row_ff;
      count_in = BYTE_PULSES;
      sum_row  = row_ff;
      sum_col  = col_ff;
      unique case (req.op)
         OP_INIT: begin
            col_in   = '0;
            row_in   = '0;
            sum_row  = '0;
            sum_col  = '0;
            count_in = INIT_PULSES;
         end
         OP_CHAR: begin
            wrap_in = (col_ff >= WRAP_COL);
            sum_col = '0;
            if (wrap_in) begin
               col_in   = '0;
               count_in = WRAP_PULSES;
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         OP_CURSOR: begin
            col_in  = req.column;
            row_in  = req.row;
            sum_col = req.column;
            sum_row = req.row;
         end
         OP_GLYPH: begin
            count_in = GLYPH_PULSES;
         end
         default: begin
         end
      endcase
      addr_in = CMD_SET_DDRAM | (row_base(sum_row) + BYTE_W'(sum_col));
   end

   // select the byte and nibble for the current pulse
   always_comb begin
      pulse_adj  = (op_ff == OP_INIT) ? (pulse_ff - PRE_PULSES) : pulse_ff;
      byte_idx   = pulse_adj[PULSE_W-1:1];
      cur_byte   = val_ff;
      rs_in      = 1'b0;
      wait_in    = 1'b0;
      single     = 1'b0;
      nib_in     = NIB_WAKE;
      shift_rows = 1'b0;
      unique case (op_ff)
         OP_INIT: begin
            if (pulse_ff < WAKE_PULSES) begin
               single  = 1'b1;
               wait_in = 1'b1;
               nib_in  = NIB_WAKE;
            end else if (pulse_ff == WAKE_PULSES) begin
               single = 1'b1;
               nib_in = NIB_4BIT;
            end else begin
               unique case (byte_idx)
                  4'd0:    cur_byte = fs_ff;
                  4'd1:    cur_byte = don_ff;
                  4'd2:    cur_byte = em_ff;
                  4'd3:    cur_byte = CMD_CLEAR;
                  default: cur_byte = addr_ff;
               endcase
            end
         end
         OP_CMD: begin
            cur_byte = val_ff;
         end
         OP_CHAR: begin
            if (wrap_ff && byte_idx == '0) begin
               cur_byte = addr_ff;
            end else begin
               cur_byte = val_ff;
               rs_in    = 1'b1;
            end
         end
         OP_CURSOR: begin
            cur_byte = addr_ff;
         end
         OP_GLYPH: begin
            if (byte_idx == '0) begin
               cur_byte = CMD_SET_CGRAM | BYTE_W'({slot_ff, 3'b000});
            end else if (byte_idx == GLYPH_CURSOR_BYTE) begin
               cur_byte = addr_ff;
            end else begin
               cur_byte   = rows_ff[BYTE_W-1:0];
               rs_in      = 1'b1;
               shift_rows = pulse_ff[0];
            end
         end
         default: begin
         end
      endcase
      if (!single) begin
         nib_in = pulse_ff[0] ? (cur_byte[NIB_W-1:0] & NIB_MASK) : cur_byte[BYTE_W-1:NIB_W];
      end
      last_in = (pulse_ff == count_ff - PULSE_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pulse_ff     <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         fs_ff        <= FUNCTION_SET_RST;
         don_ff       <= DISPLAY_ON_RST;
         em_ff        <= ENTRY_MODE_RST;
      end else begin
         if (csr.valid && csr.ready) begin
            unique case (csr.index)
               CSR_FUNCTION_SET: fs_ff  <= csr.data;
               CSR_DISPLAY_ON:   don_ff <= csr.data;
               CSR_ENTRY_MODE:   em_ff  <= csr.data;
               default: begin
               end
            endcase
         end
         if (accept && known_op) begin
            state_ff <= ST_RUN;
            op_ff    <= req.op;
            val_ff   <= req.byte_value;
            slot_ff  <= req.glyph_slot;
            rows_ff  <= req.glyph_rows;
            addr_ff  <= addr_in;
            wrap_ff  <= wrap_in;
            count_ff <= count_in;
            pulse_ff <= '0;
            col_ff   <= col_in;
            row_ff   <= row_in;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
            rs_ff        <= rs_in;
            nib_ff       <= nib_in;
            wait_ff      <= wait_in;
            last_ff      <= last_in;
            pulse_ff     <= pulse_ff + PULSE_W'(1);
            if (shift_rows) begin
               rows_ff <= rows_ff >> BYTE_W;
            end
            if (last_in) begin
               state_ff <= ST_IDLE;
            end
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

`ifndef SYNTHESIS
   a_idle_holds_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && rsp_valid_ff) |-> last_ff)
      else $error("pending pulse in idle is not the final one");

   a_pulse_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (pulse_ff < count_ff))
      else $error("pulse counter past request length");

   a_wait_only_init: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && wait_ff) |-> (op_ff == OP_INIT && nib_ff == NIB_WAKE && !rs_ff))
      else $error("long wait outside init wake-up");

   a_char_advance: assert property (@(posedge clock) disable iff (reset)
      (accept && req.op == OP_CHAR && col_ff < WRAP_COL)
      |=> (col_ff == $past(col_ff) + COL_W'(1)))
      else $error("cursor column did not advance");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> !req.ready)
      else $error("request taken while busy");
`endif

endmodule
